[sv/pbd_pkg.sv]
// Package for the PID drive block: configuration and command types, operand
// selects and fixed-point constants. No dependencies; every module imports it.
`default_nettype none

package pbd_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_DERIV_GAIN     = 3'd1,
        REG_INTEG_GAIN     = 3'd2,
        REG_INVERSE_PERIOD = 3'd3,
        REG_PWM_TOP        = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [23:0] prop_gain;
        logic signed [23:0] deriv_gain;
        logic signed [23:0] integ_gain;
        logic [15:0]        inverse_period;
        logic [15:0]        pwm_top;
    } cfg_t;

    // Multiplier operand A choices.
    typedef enum logic [2:0] {
        A_DIFF,
        A_ERR,
        A_DIP,
        A_SUM,
        A_MLO,
        A_MHI,
        A_QUOT
    } a_sel_t;

    // Multiplier operand B choices.
    typedef enum logic [2:0] {
        B_IP,
        B_KP,
        B_KD,
        B_KI,
        B_PT,
        B_RECIP
    } b_sel_t;

    // Action taken on the product register in a step.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIP,
        OP_LOAD,
        OP_ADD,
        OP_MAG,
        OP_YLOAD,
        OP_YADD,
        OP_OUT
    } acc_op_t;

    // Outcome class of a sample once the magnitude is known.
    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_SAT,
        CLS_CALC
    } duty_cls_t;

    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t op;
        logic    ychk;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DIFF_IP,
        ST_MUL_ERR_KP,
        ST_MUL_DIP_KD,
        ST_MUL_SUM_KI,
        ST_ADD_LAST,
        ST_MAGNITUDE,
        ST_MUL_MLO_PT,
        ST_MUL_MHI_PT,
        ST_ADD_HIGH,
        ST_MUL_RECIP,
        ST_OUTPUT
    } state_t;

    localparam logic [15:0] INV_PERIOD_RESET = 16'd100;
    localparam logic [15:0] PWM_TOP_RESET    = 16'd1000;

    // Duty divisor is 100 * 2^18; the 2^18 part is a shift, the 100 part is
    // a multiply by ceil(2^30 / 100) followed by a shift of 30.
    localparam logic [23:0] RECIP_100  = 24'd10737419;
    localparam logic [39:0] QUOT_LIMIT = 40'd6553600;
    localparam logic [15:0] DUTY_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

[sv/pbd_cfg_regs.sv]
// Configuration register file of the PID drive block.
// Depends on pbd_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module pbd_cfg_regs
    import pbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:      cfg_next.prop_gain      = cfg_data;
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = cfg_data;
                REG_INTEG_GAIN:     cfg_next.integ_gain     = cfg_data;
                REG_INVERSE_PERIOD: cfg_next.inverse_period = cfg_data[15:0];
                REG_PWM_TOP:        cfg_next.pwm_top        = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= '0;
            cfg_reg.deriv_gain     <= '0;
            cfg_reg.integ_gain     <= '0;
            cfg_reg.inverse_period <= INV_PERIOD_RESET;
            cfg_reg.pwm_top        <= PWM_TOP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[sv/pbd_datapath.sv]
// Datapath of the PID drive block: error registers, one shared multiplier,
// accumulator, magnitude and duty scaling, result register.
// Depends on pbd_pkg; driven step by step by pbd_ctrl.
`default_nettype none

module pbd_datapath
    import pbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire cfg_t        cfg,
    input  wire logic [15:0] setpoint,
    input  wire logic [15:0] measured_angle,
    output logic [15:0]      drive_right,
    output logic [15:0]      drive_left
);

    logic signed [16:0] prev_err_reg;
    logic signed [16:0] err_reg;
    logic signed [17:0] diff_reg;
    logic signed [17:0] sum_reg;
    logic               epos_reg;
    logic               eneg_reg;
    logic signed [59:0] prod_reg;
    logic signed [33:0] dip_reg;
    logic signed [59:0] acc_reg;
    logic [40:0]        mag_reg;
    duty_cls_t          cls_reg;
    logic [39:0]        y_reg;
    logic [15:0]        right_reg;
    logic [15:0]        left_reg;

    logic signed [16:0] err_new;
    logic signed [34:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [59:0] prod_next;
    logic signed [59:0] msel;
    duty_cls_t          mag_cls;
    logic [15:0]        duty;

    assign err_new = 17'(signed'(setpoint)) - 17'(signed'(measured_angle));

    always_comb
    begin
        unique case (cmd.a_sel)
            A_DIFF:  mul_a = 35'(diff_reg);
            A_ERR:   mul_a = 35'(err_reg);
            A_DIP:   mul_a = 35'(dip_reg);
            A_SUM:   mul_a = 35'(sum_reg);
            A_MLO:   mul_a = {17'b0, mag_reg[17:0]};
            A_MHI:   mul_a = {12'b0, mag_reg[40:18]};
            A_QUOT:  mul_a = {12'b0, y_reg[22:0]};
            default: mul_a = '0;
        endcase
        unique case (cmd.b_sel)
            B_IP:    mul_b = {9'b0, cfg.inverse_period};
            B_KP:    mul_b = 25'(cfg.prop_gain);
            B_KD:    mul_b = 25'(cfg.deriv_gain);
            B_KI:    mul_b = 25'(cfg.integ_gain);
            B_PT:    mul_b = {9'b0, cfg.pwm_top};
            B_RECIP: mul_b = {1'b0, RECIP_100};
            default: mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Magnitude in the direction of the error and its outcome class.
    always_comb
    begin
        msel = epos_reg ? acc_reg : -acc_reg;
        priority if (!(epos_reg || eneg_reg) || (cfg.pwm_top == '0) || msel[59]
                     || (msel == '0))
            mag_cls = CLS_ZERO;
        else if (|msel[58:41])
            mag_cls = CLS_SAT;
        else
            mag_cls = CLS_CALC;
    end

    always_comb
    begin
        unique case (cls_reg)
            CLS_SAT:  duty = DUTY_MAX;
            CLS_CALC: duty = prod_reg[45:30];
            default:  duty = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
        end
        else if (cmd.load_in)
        begin
            prev_err_reg <= err_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            err_reg  <= err_new;
            diff_reg <= 18'(err_new) - 18'(prev_err_reg);
            sum_reg  <= 18'(err_new) + 18'(prev_err_reg);
            epos_reg <= !err_new[16] && (err_new != '0);
            eneg_reg <= err_new[16];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        unique case (cmd.op)
            OP_DIP:   dip_reg <= prod_reg[33:0];
            OP_LOAD:  acc_reg <= prod_reg;
            OP_ADD:   acc_reg <= acc_reg + prod_reg;
            OP_MAG:
            begin
                mag_reg <= msel[40:0];
                cls_reg <= mag_cls;
            end
            OP_YLOAD: y_reg <= {24'b0, prod_reg[33:18]};
            OP_YADD:  y_reg <= y_reg + prod_reg[39:0];
            OP_OUT:
            begin
                right_reg <= epos_reg ? duty : '0;
                left_reg  <= eneg_reg ? duty : '0;
            end
            default:  ;
        endcase
        if (cmd.ychk && (cls_reg == CLS_CALC) && (y_reg >= QUOT_LIMIT))
        begin
            cls_reg <= CLS_SAT;
        end
    end

    assign drive_right = right_reg;
    assign drive_left  = left_reg;

    // Only one direction is ever driven by a result.
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |=> (right_reg == '0) || (left_reg == '0))
        else $error("both drive channels nonzero");

    // A computed duty always starts from a nonzero magnitude.
    a_calc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MAG) |=> (cls_reg != CLS_CALC) || (mag_reg != '0))
        else $error("computed class with zero magnitude");

    // The reciprocal quotient fits the output width in the computed class.
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_OUT) && (cls_reg == CLS_CALC)) |-> (prod_reg[59:46] == '0))
        else $error("duty quotient overflow");

endmodule

`default_nettype wire

[sv/pbd_ctrl.sv]
// Controller of the PID drive block: sequences the shared multiplier steps
// and owns the input ready and output valid. Depends on pbd_pkg.
`default_nettype none

module pbd_ctrl
    import pbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output dp_cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.load_in   = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.a_sel     = A_DIFF;
        cmd.b_sel     = B_IP;
        cmd.op        = OP_NONE;
        cmd.ychk      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL_DIFF_IP;
                end
            end
            ST_MUL_DIFF_IP:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_MUL_ERR_KP;
            end
            ST_MUL_ERR_KP:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = A_ERR;
                cmd.b_sel  = B_KP;
                cmd.op     = OP_DIP;
                state_next = ST_MUL_DIP_KD;
            end
            ST_MUL_DIP_KD:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = A_DIP;
                cmd.b_sel  = B_KD;
                cmd.op     = OP_LOAD;
                state_next = ST_MUL_SUM_KI;
            end
            ST_MUL_SUM_KI:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = A_SUM;
                cmd.b_sel  = B_KI;
                cmd.op     = OP_ADD;
                state_next = ST_ADD_LAST;
            end
            ST_ADD_LAST:
            begin
                cmd.op     = OP_ADD;
                state_next = ST_MAGNITUDE;
            end
            ST_MAGNITUDE:
            begin
                cmd.op     = OP_MAG;
                state_next = ST_MUL_MLO_PT;
            end
            ST_MUL_MLO_PT:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = A_MLO;
                cmd.b_sel  = B_PT;
                state_next = ST_MUL_MHI_PT;
            end
            ST_MUL_MHI_PT:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = A_MHI;
                cmd.b_sel  = B_PT;
                cmd.op     = OP_YLOAD;
                state_next = ST_ADD_HIGH;
            end
            ST_ADD_HIGH:
            begin
                cmd.op     = OP_YADD;
                state_next = ST_MUL_RECIP;
            end
            ST_MUL_RECIP:
            begin
                cmd.mul_en = 1'b1;
                cmd.a_sel  = A_QUOT;
                cmd.b_sel  = B_RECIP;
                cmd.ychk   = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    cmd.op        = OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL_DIFF_IP))
        else $error("accepted sample did not start the sequence");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUTPUT))
        else $error("result raised outside the output step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[sv/pid_bidirectional_drive.sv]
// Top level of the PID drive block: configuration registers, controller and
// datapath. Depends on pbd_pkg, pbd_cfg_regs, pbd_ctrl and pbd_datapath.
//
//  Channel  Signals                         Payload
//  -------  ------------------------------  ---------------------------------
//  s_       s_tvalid, s_tready, s_tdata     [15:0] setpoint, [31:16] measured
//  m_       m_tvalid, m_tready, m_tdata     [15:0] drive_right, [31:16] left
//  cfg_     cfg_valid, cfg_ready, cfg_*     cfg_index 0..4, cfg_data 24 bits
//
// From its transfer to its result being offered, a sample walks the controller
// steps: the single 35x25 multiplier is used seven times in sequence, with add,
// magnitude and output steps in between. The next sample is taken in the cycle
// after the result is loaded, even while that result still waits on m_tready;
// a result stalls in its last step only while the previous result is
// still unread.
// Reset clears the previous error and sets the registers to their defaults.
`default_nettype none

module pid_bidirectional_drive
    import pbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] setpoint, [31:16] measured_angle
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] drive_right, [31:16] drive_left
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    cfg_t        cfg;
    dp_cmd_t     cmd;
    logic [15:0] drive_right;
    logic [15:0] drive_left;

    pbd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The controller walks the multiplier schedule; the datapath does the math.
    pbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pbd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .setpoint       (s_tdata[15:0]),
        .measured_angle (s_tdata[31:16]),
        .drive_right    (drive_right),
        .drive_left     (drive_left)
    );

    assign m_tdata = {drive_left, drive_right};

endmodule

`default_nettype wire

[dv/pbd_checker.sv]
// Scoreboard for the PID drive block: watches the sample, result and register
// channels, predicts every drive result and compares it field by field.
// Depends on pbd_pkg for the register indexes and the configuration layout.

module pbd_checker
    import pbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] setpoint, [31:16] measured_angle
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [15:0] drive_right, [31:16] drive_left
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    output int               errors,
    output int               outstanding,
    output int               checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Laid out like m_tdata so that a result word can be assigned directly.
    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
    } drive_t;

    // 100 percent times the 2^18 scale of gain times angle.
    localparam longint DUTY_DIV = 64'sd26214400;

    cfg_t    regs;
    longint  err_prev;
    drive_t  expected_drive[$];
    int      fail_count;
    int      match_count;

    // Compare count for a drive magnitude, truncated and clipped to 16 bits.
    function automatic logic [15:0] duty_count(input longint mag, input logic [15:0] top);
        longint span;
        longint whole;
        longint rest;
        longint duty;
        if (mag <= 0)
            return 16'd0;
        span  = top;
        whole = mag / DUTY_DIV;
        rest  = mag % DUTY_DIV;
        if (whole > 64'sd16777215)
            whole = 64'sd16777215;
        duty = whole * span + (rest * span) / DUTY_DIV;
        if (duty > 64'sd65535)
            duty = 64'sd65535;
        return duty[15:0];
    endfunction

    function automatic drive_t pid_drive(input logic signed [15:0] sp,
                                         input logic signed [15:0] meas,
                                         input longint e_prev, input cfg_t c,
                                         output longint err);
        longint rate;
        longint total;
        drive_t d;
        err   = longint'(sp) - longint'(meas);
        rate  = c.inverse_period;
        total = err * longint'(c.prop_gain)
              + (err - e_prev) * rate * longint'(c.deriv_gain)
              + (err + e_prev) * longint'(c.integ_gain);
        d = '0;
        if (err > 0)
            d.right = duty_count(total, c.pwm_top);
        else if (err < 0)
            d.left = duty_count(-total, c.pwm_top);
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_t got;
        drive_t want;
        longint err_now;
        if (!rst_n)
        begin
            regs.prop_gain      = '0;
            regs.deriv_gain     = '0;
            regs.integ_gain     = '0;
            regs.inverse_period = INV_PERIOD_RESET;
            regs.pwm_top        = PWM_TOP_RESET;
            err_prev            = 0;
            fail_count          = 0;
            match_count         = 0;
            expected_drive.delete();
        end
        else
        begin
            // Results leave before a new sample is queued, so a stray result
            // can never be matched against the sample entering on this edge.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_drive.size() == 0)
                begin
                    $display("%0t: drive result right=%0d left=%0d with none expected",
                             $time, got.right, got.left);
                    fail_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (got.right !== want.right)
                    begin
                        $display("%0t: drive_right expected %0d, got %0d",
                                 $time, want.right, got.right);
                        fail_count++;
                    end
                    if (got.left !== want.left)
                    begin
                        $display("%0t: drive_left expected %0d, got %0d",
                                 $time, want.left, got.left);
                        fail_count++;
                    end
                    match_count++;
                end
            end

            if (s_tvalid && s_tready)
            begin
                want = pid_drive(s_tdata[15:0], s_tdata[31:16], err_prev, regs, err_now);
                expected_drive.push_back(want);
                err_prev = err_now;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:      regs.prop_gain      = cfg_data;
                    REG_DERIV_GAIN:     regs.deriv_gain     = cfg_data;
                    REG_INTEG_GAIN:     regs.integ_gain     = cfg_data;
                    REG_INVERSE_PERIOD: regs.inverse_period = cfg_data[15:0];
                    REG_PWM_TOP:        regs.pwm_top        = cfg_data[15:0];
                    default:            ;
                endcase
            end
        end
        errors      <= fail_count;
        outstanding <= expected_drive.size();
        checked     <= match_count;
    end

endmodule

[dv/tb_pid_bidirectional_drive.sv]
// Top of the PID drive testbench: clock, reset, sample and register stimulus,
// result back-pressure and the verdict. Depends on pbd_pkg, pbd_checker and the RTL.

module tb_pid_bidirectional_drive
    import pbd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Latency of a sample from its transfer to its result; the tail wait
    // at the end of the run allows twice that.
    localparam int LATENCY         = 11;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLDOFF_CYCLES  = 300;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT     = 3000;
    localparam int RANDOM_PHASES   = 8;
    localparam int SAMPLES_PER_SET = 205;
    // An index past the end of the register list; writes to it are dropped.
    localparam logic [2:0] IDX_UNUSED = 3'd5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;         // [15:0] setpoint, [31:16] measured_angle
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;              // [15:0] drive_right, [31:16] drive_left
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    int fail_count;
    int outstanding;
    int results_checked;

    // Sender idle and receiver stall rates, in percent of cycles.
    int idle_pct = 0;
    int stall_pct = 0;
    // The stimulus asks for a hold-off by bumping holds_asked; the receiver
    // process serves it and counts the stretch down itself.
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    int samples_sent = 0;
    int cfg_writes = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    pid_bidirectional_drive dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pbd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (fail_count),
        .outstanding (outstanding),
        .checked     (results_checked)
    );

    // Result-side back-pressure. A pending hold-off request takes priority
    // over the random stall rate; while it runs, ready stays low throughout.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (holds_served < holds_asked)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLDOFF_CYCLES;
            m_tready     <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results still expected",
                     $time, quiet_cycles, outstanding);
            $display("tb_pid_bidirectional_drive failed");
            $finish;
        end
    end

    // Offers one register write and holds it until the transfer. Valid is
    // left high so that back-to-back writes never drop it for a cycle.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_writes++;
    endtask

    // Writes every register once. Only called while the block is idle.
    task automatic program_gains(input logic [23:0] kp, input logic [23:0] kd,
                                 input logic [23:0] ki, input logic [15:0] rate,
                                 input logic [15:0] top);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_INVERSE_PERIOD, {8'd0, rate});
        write_reg(REG_PWM_TOP, {8'd0, top});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Offers one sample, first idling the sender for a random number of
    // cycles at the current rate. Valid stays high after the transfer, so a
    // sample that follows without a gap is offered with no drop in valid.
    task automatic send_sample(input logic [15:0] sp, input logic [15:0] meas);
        int gap;
        gap = 0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {meas, sp};
        do @(posedge clk); while (!s_tready);
        samples_sent++;
    endtask

    // Stops offering and waits until every expected result has been seen.
    // The wait begins with a clock edge, because the checker's count is only
    // updated in the cycle after the transfer that was just made.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Angles are mostly inside the mechanical range, with its edges and the
    // full 16-bit span mixed in so that every input bit toggles.
    function automatic int pick_angle();
        case ($urandom_range(9))
            0:       return int'($urandom_range(65535)) - 32768;
            1:       return 23040;
            2:       return -23040;
            default: return int'($urandom_range(46080)) - 23040;
        endcase
    endfunction

    // Gains cluster around a usable magnitude but hit zero and both ends too.
    function automatic logic [23:0] pick_gain(input int span);
        int v;
        case ($urandom_range(9))
            0:       v = -8388608;
            1:       v = 8388607;
            2:       v = 0;
            3:       v = int'($urandom_range(16777215)) - 8388608;
            default: v = int'($urandom_range(2 * span)) - span;
        endcase
        return v[23:0];
    endfunction

    function automatic logic [15:0] pick_u16(input int lo, input int hi);
        int v;
        case ($urandom_range(9))
            0:       v = 1;
            1:       v = 65535;
            2:       v = 0;
            default: v = $urandom_range(hi, lo);
        endcase
        return v[15:0];
    endfunction

    // Most samples sit close to the setpoint so that the derivative and
    // two-sample integral terms stay meaningful; some land exactly on it.
    task automatic send_random_sample();
        int sp;
        int meas;
        sp = pick_angle();
        case ($urandom_range(9))
            0:       meas = sp;
            1, 2, 3: meas = pick_angle();
            default: meas = sp + int'($urandom_range(800)) - 400;
        endcase
        send_sample(sp[15:0], meas[15:0]);
    endtask

    initial
    begin
        int phase;
        int n;

        // Reset is applied once, here, and never again.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A write past the register list comes first; it
        // must leave every register untouched.
        write_reg(IDX_UNUSED, 24'hFFFFFF);
        program_gains(24'd4096, 24'd2048, 24'd1024, 16'd100, 16'd1000);
        send_sample(16'sd0, 16'sd0);            // zero error from reset
        send_sample(16'sd640, 16'sd0);          // plain positive error
        send_sample(16'sd0, 16'sd640);          // sign flip, large derivative
        send_sample(16'sd640, 16'sd640);        // zero error after a negative one
        send_sample(16'sh7FFF, 16'sh8000);      // widest positive error
        send_sample(16'sh8000, 16'sh7FFF);      // widest negative error
        send_sample(16'sd23040, -16'sd23040);
        send_sample(-16'sd23040, 16'sd23040);
        send_sample(16'sd1, 16'sd0);            // smallest positive error
        send_sample(16'sd0, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd100, 16'sd99);
        drain_results();

        // Negative proportional gain gives a total against the error, which drives
        // nothing; a zero rate kills the derivative term despite a huge derivative gain.
        program_gains(-24'sd4096, 24'h7FFFFF, 24'd0, 16'd0, 16'hFFFF);
        send_sample(16'sd1000, 16'sd0);
        send_sample(16'sd0, 16'sd1000);
        send_sample(16'sd5, 16'sd5);
        send_sample(16'sh8000, 16'sh8000);
        drain_results();

        // Extreme gains with a zero PWM top: nothing may be driven.
        program_gains(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'd0);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sd2, 16'sd1);
        drain_results();

        // Smallest nonzero rate and PWM top.
        program_gains(24'h7FFFFF, 24'h800000, 24'h800000, 16'd1, 16'd1);
        send_sample(16'sd12, 16'sd0);
        send_sample(-16'sd12, 16'sd0);
        send_sample(16'sd300, 16'sd0);
        drain_results();

        // Random part: each phase picks a setting and an idling mix. Phase
        // one and phase five pin the rate and PWM top to two opposite corners.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 1)
                program_gains(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
            else if (phase == 5)
                program_gains(24'd8192, 24'd64, 24'd512, 16'd1, 16'd1);
            else
                program_gains(pick_gain(16384), pick_gain(128), pick_gain(8192),
                              pick_u16(1, 1000), pick_u16(100, 4000));

            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 46; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase

            // With the sender never idle, a long receiver hold-off fills the
            // pipeline and must push back on the sample channel.
            if (phase == 4)
                holds_asked++;

            for (n = 0; n < SAMPLES_PER_SET; n++)
            begin
                // Midway through one phase the sender lets the block run dry
                // before carrying on with the same setting.
                if (phase == 6 && n == SAMPLES_PER_SET / 2)
                    drain_results();
                send_random_sample();
            end
            drain_results();
        end

        // Nothing is expected now; give a stray result time to show up.
        repeat (2 * LATENCY) @(posedge clk);

        $display("Ran %0d samples under %0d gain settings with %0d register writes,",
                 samples_sent, settings_used, cfg_writes);
        $display("checking %0d drive results across four idling mixes and one long hold-off.",
                 results_checked);
        if (fail_count == 0)
            $display("tb_pid_bidirectional_drive passed");
        else
            $display("tb_pid_bidirectional_drive failed");
        $finish;
    end

endmodule
